// ===== src/fkls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkls_pkg
// Shared types and constants for the fixed-key lower-bound search block.
// ----------------------------------------------------------------------------
package fkls_pkg;

    localparam int SLOT_W         = 10;
    localparam int ROW_W          = 10;
    localparam int POS_W          = 11;
    localparam int KEY_FIELD_W    = 64;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int TABLE_ROWS_DEF = 1024;

    typedef enum logic [1:0] {
        OP_WR_KEY = 2'd0,
        OP_WR_ORD = 2'd1,
        OP_SEARCH = 2'd2,
        OP_READ   = 2'd3
    } fkls_op_t;

    typedef struct packed {
        fkls_op_t                 opcode;
        logic [SLOT_W-1:0]        slot;
        logic [KEY_FIELD_W-1:0]   key_value;
        logic [ROW_W-1:0]         row_number;
    } fkls_req_t;

    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic                     found;
        logic [ROW_W-1:0]         hit_row;
        logic [KEY_FIELD_W-1:0]   key_out;
    } fkls_resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_PROBE_ORD,
        ST_PROBE_KEY,
        ST_HIT_ORD,
        ST_HIT_KEY,
        ST_READ,
        ST_READ_KEY,
        ST_EMIT
    } fkls_state_t;

    typedef struct packed {
        logic load;         // latch new request
        logic ord_sel_mid;  // order RAM address = midpoint
        logic ord_sel_lo;   // order RAM address = lower bound
        logic ord_we;
        logic key_sel_ord;  // key RAM address = order RAM data
        logic key_we;
        logic step;         // narrow the search window
        logic hit_row_cap;
        logic hit_cap;
        logic rd_cap;
        logic emit;
    } fkls_cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic lo_lt_n;
        logic slot_ok;
        logic out_free;
    } fkls_sts_t;

endpackage

// ===== src/fkls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkls_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module fkls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fkls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkls_ctrl
// Sequencer for writes, reads and the binary lower-bound search.
// ----------------------------------------------------------------------------
module fkls_ctrl
    import fkls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  fkls_op_t  in_op,
    output logic      s_ready,
    output fkls_cmd_t cmd,
    input  fkls_sts_t sts
);

    fkls_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (in_op)
                        OP_WR_KEY, OP_WR_ORD: state_next = ST_WRITE;
                        OP_SEARCH:            state_next = ST_CHECK;
                        OP_READ:              state_next = ST_READ;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:     state_next = ST_IDLE;
            ST_CHECK: begin
                priority if (sts.lo_lt_hi) begin
                    state_next = ST_PROBE_ORD;
                end else if (sts.lo_lt_n) begin
                    state_next = ST_HIT_ORD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PROBE_ORD: state_next = ST_PROBE_KEY;
            ST_PROBE_KEY: state_next = ST_CHECK;
            ST_HIT_ORD:   state_next = ST_HIT_KEY;
            ST_HIT_KEY:   state_next = ST_EMIT;
            ST_READ:      state_next = sts.slot_ok ? ST_READ_KEY : ST_EMIT;
            ST_READ_KEY:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_WRITE: begin
                cmd.ord_we = 1'b1;
                cmd.key_we = 1'b1;
            end
            ST_CHECK: begin
                cmd.ord_sel_mid = sts.lo_lt_hi;
                cmd.ord_sel_lo  = ~sts.lo_lt_hi;
            end
            ST_PROBE_ORD: cmd.key_sel_ord = 1'b1;
            ST_PROBE_KEY: cmd.step        = 1'b1;
            ST_HIT_ORD: begin
                cmd.key_sel_ord = 1'b1;
                cmd.hit_row_cap = 1'b1;
            end
            ST_HIT_KEY:   cmd.hit_cap = 1'b1;
            ST_READ:      ;
            ST_READ_KEY:  cmd.rd_cap  = 1'b1;
            ST_EMIT:      cmd.emit    = sts.out_free;
            default:      ;
        endcase
    end

endmodule

// ===== src/fkls_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkls_datapath
// Request registers, search window, key and order RAMs, result register.
// ----------------------------------------------------------------------------
module fkls_datapath
    import fkls_pkg::*;
#(
    parameter int KEY_BYTES  = KEY_BYTES_DEF,
    parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [POS_W-1:0] cfg_wr_data,
    input  fkls_req_t        s_req,
    input  fkls_cmd_t        cmd,
    output fkls_sts_t        sts,
    output logic             m_valid,
    input  logic             m_ready,
    output fkls_resp_t       m_resp
);

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int AW    = $clog2(TABLE_ROWS);

    logic [POS_W-1:0]  rows_in_use_reg;
    fkls_op_t          op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [ROW_W-1:0]  rown_reg;
    logic [POS_W-1:0]  n_reg, lo_reg, hi_reg, mid_reg;
    logic              row_ok_reg;
    logic [ROW_W-1:0]  hit_row_reg;
    logic              found_reg;
    logic [KEY_W-1:0]  key_out_reg;
    fkls_resp_t        resp_reg;
    logic              m_valid_reg;

    logic [POS_W-1:0]  n_sat;
    logic [POS_W-1:0]  mid;
    logic [AW-1:0]     ord_addr, key_addr;
    logic [ROW_W-1:0]  ord_rdata;
    logic [KEY_W-1:0]  key_rdata;
    logic [KEY_W-1:0]  probe_key;
    logic              slot_ok;

    assign n_sat = (32'(rows_in_use_reg) > 32'(TABLE_ROWS)) ? POS_W'(TABLE_ROWS)
                                                            : rows_in_use_reg;
    assign mid       = POS_W'((({1'b0, lo_reg}) + ({1'b0, hi_reg})) >> 1);
    assign slot_ok   = 32'(slot_reg) < 32'(TABLE_ROWS);
    assign probe_key = row_ok_reg ? key_rdata : '0;

    always_comb begin
        priority if (cmd.ord_sel_mid) begin
            ord_addr = AW'(mid);
        end else if (cmd.ord_sel_lo) begin
            ord_addr = AW'(lo_reg);
        end else begin
            ord_addr = AW'(slot_reg);
        end
    end

    assign key_addr = cmd.key_sel_ord ? AW'(ord_rdata) : AW'(slot_reg);

    fkls_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ROWS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.key_we && op_reg == OP_WR_KEY && slot_ok),
        .addr  (key_addr),
        .wdata (key_reg),
        .rdata (key_rdata)
    );

    fkls_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ROWS)
    ) u_ord_ram (
        .aclk  (aclk),
        .we    (cmd.ord_we && op_reg == OP_WR_ORD && slot_ok),
        .addr  (ord_addr),
        .wdata (rown_reg),
        .rdata (ord_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg <= '0;
        end else if (cfg_wr_en) begin
            rows_in_use_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_req.opcode;
            slot_reg    <= s_req.slot;
            key_reg     <= s_req.key_value[KEY_W-1:0];
            rown_reg    <= s_req.row_number;
            n_reg       <= n_sat;
            lo_reg      <= '0;
            hi_reg      <= n_sat;
            found_reg   <= 1'b0;
            key_out_reg <= '0;
            hit_row_reg <= (s_req.opcode == OP_READ) ? s_req.slot : '0;
        end else begin
            if (cmd.ord_sel_mid) begin
                mid_reg <= mid;
            end
            if (cmd.key_sel_ord) begin
                row_ok_reg <= 32'(ord_rdata) < 32'(TABLE_ROWS);
            end
            if (cmd.step) begin
                if (probe_key < key_reg) begin
                    lo_reg <= mid_reg + POS_W'(1);
                end else begin
                    hi_reg <= mid_reg;
                end
            end
            if (cmd.hit_row_cap) begin
                hit_row_reg <= ord_rdata;
            end
            if (cmd.hit_cap) begin
                found_reg <= (probe_key == key_reg);
            end
            if (cmd.rd_cap) begin
                key_out_reg <= key_rdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            resp_reg.position <= lo_reg;
            resp_reg.found    <= found_reg;
            resp_reg.hit_row  <= hit_row_reg;
            resp_reg.key_out  <= KEY_FIELD_W'(key_out_reg);
        end
    end

    assign sts.lo_lt_hi = lo_reg < hi_reg;
    assign sts.lo_lt_n  = lo_reg < n_reg;
    assign sts.slot_ok  = slot_ok;
    assign sts.out_free = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_resp  = resp_reg;

endmodule

// ===== src/fixed_key_lower_bound_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_key_lower_bound_search
// Key table with sort-order table and binary lower-bound search.
// ----------------------------------------------------------------------------
// Requests enter on s_valid/s_ready with an s_req payload; results leave on
// m_valid/m_ready with an m_resp payload. cfg_wr_en/cfg_wr_data set the row
// count used by searches; write it only while the block is idle.
// One request is worked on at a time; s_ready is high only when idle.
//   key or order write : no result
//   read               : key RAM read at the slot, then the result
//   search             : one probe per window step, then a hit check unless past
//                        the end; at most ceil(log2(n+1)) probes
// Each probe reads the order RAM, then the key RAM with that row, then
// compares; these two registered single-port RAM reads set the pace.
// The result sits in an output register; while it waits the next request
// can be taken, but that request's result holds in the sequencer until the
// register is free. Reset (aresetn, synchronous) clears the sequencer, the
// row count and m_valid; table contents are undefined until written.
// ----------------------------------------------------------------------------
module fixed_key_lower_bound_search
    import fkls_pkg::*;
#(
    parameter int KEY_BYTES  = KEY_BYTES_DEF,
    parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [POS_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  fkls_req_t        s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output fkls_resp_t       m_resp
);

    fkls_cmd_t cmd;
    fkls_sts_t sts;

    fkls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_op   (s_req.opcode),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    fkls_datapath #(
        .KEY_BYTES  (KEY_BYTES),
        .TABLE_ROWS (TABLE_ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_req       (s_req),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_resp      (m_resp)
    );

endmodule

// ===== src/fkls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkls_assertions
// Port-level checks for the lower-bound search block.
// ----------------------------------------------------------------------------
module fkls_assertions
    import fkls_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input fkls_req_t  s_req,
    input logic       m_valid,
    input logic       m_ready,
    input fkls_resp_t m_resp
);

    // stalled result holds
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_resp))
        else $error("result changed while stalled");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // a match only comes from a search, which returns no key bytes
    a_found_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_resp.found |-> m_resp.key_out == '0)
        else $error("match flagged on a read result");

    // results are issued from the busy sequencer, never while idle
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result issued while idle");

    // a write never leads straight to a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid &&
        (s_req.opcode == OP_WR_KEY || s_req.opcode == OP_WR_ORD) |=> !m_valid)
        else $error("result after a write");

endmodule

bind fixed_key_lower_bound_search fkls_assertions u_fkls_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_resp  (m_resp)
);
